/* design/fbcc_pkg.sv */
// fbcc_pkg: types, frame layout constants and the CRC word function
// for the frame block checksum and CRC unit. No dependencies.
`default_nettype none
package fbcc_pkg;

    localparam int POS_W = 7;
    localparam int OFF_W = 5;
    localparam int BLK_W = 2;

    localparam logic [POS_W-1:0] POS_LAST       = 7'd115;
    localparam logic [POS_W-1:0] POS_FIRST_BLK  = 7'd4;
    localparam logic [POS_W-1:0] POS_CRC_LAST   = 7'd114;
    localparam logic [OFF_W-1:0] OFF_STRIDE_END = 5'd27;
    localparam logic [OFF_W-1:0] OFF_BLK_END    = 5'd26;
    localparam logic [BLK_W-1:0] BLK_FINAL      = 2'd3;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_POLY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_PAD  = 1'b1;

    typedef struct packed {
        logic [31:0] data_word;
        logic [7:0]  xor_seed;
        logic [7:0]  sum_seed;
    } t_in;

    typedef struct packed {
        logic [1:0]  block_index;
        logic [7:0]  xor_check;
        logic [7:0]  sum_check;
        logic [31:0] crc_value;
        logic        crc_valid;
    } t_out;

    typedef struct packed {
        logic             crc_load;
        logic             crc_step;
        logic             in_blk;
        logic             blk_first;
        logic             blk_last;
        logic             crc_done;
        logic [BLK_W-1:0] blk;
    } t_ctrl;

    // 32 bit steps, LSB first, right-shifting register
    function automatic logic [31:0] crc_word(input logic [31:0] crc,
                                             input logic [31:0] word,
                                             input logic [31:0] poly);
        logic [31:0] r;
        logic        low;
        r = crc;
        for (int b = 0; b < 32; b++) begin
            low = r[0];
            r = {word[b], r[31:1]};
            if (low) begin
                r = r ^ poly;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/fbcc_ctrl.sv */
// fbcc_ctrl: frame position tracking; decodes block and CRC phases per beat.
// Depends on fbcc_pkg.
`default_nettype none
module fbcc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    output fbcc_pkg::t_ctrl      o_ctrl
);

    logic [fbcc_pkg::POS_W-1:0] r_pos, n_pos;
    logic [fbcc_pkg::OFF_W-1:0] r_off, n_off;
    logic [fbcc_pkg::BLK_W-1:0] r_blk, n_blk;

    always_comb begin
        o_ctrl.crc_load  = (r_pos == '0);
        o_ctrl.crc_step  = (r_pos != '0) && (r_pos <= fbcc_pkg::POS_CRC_LAST);
        o_ctrl.in_blk    = (r_pos >= fbcc_pkg::POS_FIRST_BLK)
                        && (r_pos <= fbcc_pkg::POS_CRC_LAST)
                        && (r_off <= fbcc_pkg::OFF_BLK_END);
        o_ctrl.blk_first = o_ctrl.in_blk && (r_off == '0);
        o_ctrl.blk_last  = o_ctrl.in_blk && (r_off == fbcc_pkg::OFF_BLK_END);
        o_ctrl.crc_done  = o_ctrl.blk_last && (r_blk == fbcc_pkg::BLK_FINAL);
        o_ctrl.blk       = r_blk;
    end

    always_comb begin
        n_pos = r_pos;
        n_off = r_off;
        n_blk = r_blk;
        if (i_accept) begin
            n_pos = (r_pos == fbcc_pkg::POS_LAST) ? '0 : r_pos + 1'b1;
            if (r_pos == fbcc_pkg::POS_FIRST_BLK - 1'b1) begin
                n_off = '0;
                n_blk = '0;
            end else if (r_pos >= fbcc_pkg::POS_FIRST_BLK) begin
                if (r_off == fbcc_pkg::OFF_STRIDE_END) begin
                    n_off = '0;
                    n_blk = r_blk + 1'b1;
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_off <= '0;
            r_blk <= '0;
        end else begin
            r_pos <= n_pos;
            r_off <= n_off;
            r_blk <= n_blk;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= fbcc_pkg::POS_LAST)
        else $error("frame position out of range");
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_pos == fbcc_pkg::POS_LAST) |=> (r_pos == '0))
        else $error("frame position did not wrap");
    a_first_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == fbcc_pkg::POS_FIRST_BLK) |-> (r_off == '0 && r_blk == '0))
        else $error("block counters misaligned at first block word");
`endif

endmodule
`default_nettype wire

/* design/frame_block_checksum_crc.sv */
// Frame block checksum and CRC unit, top level.
// Depends on fbcc_pkg and fbcc_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in_data) takes one
//   32-bit frame word per beat, 116 words to a frame, position counted
//   internally from reset. Output channel (o_out_valid / i_out_stall,
//   payload o_out_data) gives one beat after the last word of each of the
//   four blocks (words 30, 58, 86, 114); the beat after word 114 also
//   carries the frame CRC with crc_valid set.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr
//   (0 polynomial, 1 pad); write only while idle.
//   Throughput: one word per cycle while o_in_stall is low; CRC update is a
//   combinational XOR network and checksums are one 4-byte add/xor per beat.
//   Stall: results go to an output register backed by a one-entry skid
//   buffer; o_in_stall is raised only while the skid entry is occupied.
//   Reset (synchronous, active low) clears position, accumulators, CRC and
//   output valids and restores the register defaults.
`default_nettype none
module frame_block_checksum_crc (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  fbcc_pkg::t_in                         i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output fbcc_pkg::t_out                        o_out_data,
    input  wire                                   i_cfg_we,
    input  wire [fbcc_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire [31:0]                            i_cfg_data
);

    fbcc_pkg::t_ctrl ctrl;
    logic            accept;

    logic [31:0] r_poly, r_pad;
    logic [31:0] r_crc, n_crc;
    logic [7:0]  r_xacc, n_xacc;
    logic [7:0]  r_sacc, n_sacc;
    logic [31:0] crc_stepped;
    logic [7:0]  x_base, s_base;

    fbcc_pkg::t_out res;
    logic           res_valid;

    logic           r_out_valid, r_skid_valid;
    fbcc_pkg::t_out r_out, r_skid;
    logic           out_take;

    assign accept = i_in_valid && !o_in_stall;

    fbcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .o_ctrl   (ctrl)
    );

    assign crc_stepped = fbcc_pkg::crc_word(r_crc, i_in_data.data_word, r_poly);

    always_comb begin
        n_crc = r_crc;
        if (ctrl.crc_load) begin
            n_crc = i_in_data.data_word ^ (i_in_data.data_word[0] ? r_poly : 32'd0);
        end else if (ctrl.crc_step) begin
            n_crc = crc_stepped;
        end

        x_base = ctrl.blk_first ? i_in_data.xor_seed : r_xacc;
        s_base = ctrl.blk_first ? i_in_data.sum_seed : r_sacc;
        n_xacc = x_base ^ i_in_data.data_word[7:0] ^ i_in_data.data_word[15:8]
               ^ i_in_data.data_word[23:16] ^ i_in_data.data_word[31:24];
        n_sacc = s_base + i_in_data.data_word[7:0] + i_in_data.data_word[15:8]
               + i_in_data.data_word[23:16] + i_in_data.data_word[31:24];

        res.block_index = ctrl.blk;
        res.xor_check   = n_xacc;
        res.sum_check   = 8'd0 - n_sacc;
        res.crc_value   = ctrl.crc_done ? (crc_stepped ^ r_pad) : 32'd0;
        res.crc_valid   = ctrl.crc_done;
        res_valid       = accept && ctrl.blk_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= 32'hEDB8_8320;
            r_pad  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fbcc_pkg::CFG_CRC_POLY: r_poly <= i_cfg_data;
                fbcc_pkg::CFG_CRC_PAD:  r_pad  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_xacc <= '0;
            r_sacc <= '0;
        end else if (accept) begin
            r_crc <= n_crc;
            if (ctrl.in_blk) begin
                r_xacc <= n_xacc;
                r_sacc <= n_sacc;
            end
        end
    end

    // output register with one-entry skid
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost under stall");
    a_crc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.crc_valid) |-> (o_out_data.block_index == fbcc_pkg::BLK_FINAL))
        else $error("crc flagged on wrong block");
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !r_out_valid) |=> o_out_valid)
        else $error("result not presented");
`endif

endmodule
`default_nettype wire
